// ===== design/afk_pkg.sv =====
// ----------------------------------------------------------------------------
// afk_pkg
// Shared constants, atan table and helpers for the arm kinematics pipeline.
// ----------------------------------------------------------------------------
package afk_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ATAN_ENTRIES        = 24;

  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [16:0]        TOOL_OFFSET = 17'd4260;

  localparam logic [1:0] REG_UPPER = 2'd0;
  localparam logic [1:0] REG_FORE  = 2'd1;
  localparam logic [1:0] REG_WRIST = 2'd2;

  function automatic logic signed [31:0] atan_q30(input int i);
    case (i)
      0: return 32'sd843314856;   1: return 32'sd497837829;
      2: return 32'sd263043836;   3: return 32'sd133525158;
      4: return 32'sd67021686;    5: return 32'sd33543515;
      6: return 32'sd16775850;    7: return 32'sd8388437;
      8: return 32'sd4194282;     9: return 32'sd2097149;
      10: return 32'sd1048575;    11: return 32'sd524287;
      12: return 32'sd262143;     13: return 32'sd131071;
      14: return 32'sd65535;      15: return 32'sd32767;
      16: return 32'sd16383;      17: return 32'sd8191;
      18: return 32'sd4095;       19: return 32'sd2047;
      20: return 32'sd1023;       21: return 32'sd511;
      22: return 32'sd255;        23: return 32'sd127;
      default: return 32'sd0;
    endcase
  endfunction

endpackage

// ===== design/afk_sincos.sv =====
// ----------------------------------------------------------------------------
// afk_sincos
// Pipelined sine/cosine: range reduction, fold, one CORDIC stage per register.
// The pipeline advances only when en is high.
// ----------------------------------------------------------------------------
module afk_sincos
  import afk_pkg::*;
#(
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [17:0] angle,
  output logic signed [33:0] sin_q30,
  output logic signed [33:0] cos_q30
);

  localparam int SH = 30 - ANGLE_FRAC_BITS_DEF;
  localparam int N  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  // wrap to (-pi, pi]; |a| < 3.9*pi at most so two steps suffice
  logic signed [37:0] a_full, a_w1, a_w2;
  logic signed [35:0] a_red;
  logic signed [35:0] red_q;

  always_comb begin
    a_full = 38'(angle) <<< SH;
    if (a_full > 38'(Q30_PI)) a_w1 = a_full - 38'(Q30_TWO_PI);
    else if (a_full <= -38'(Q30_PI)) a_w1 = a_full + 38'(Q30_TWO_PI);
    else a_w1 = a_full;
    if (a_w1 > 38'(Q30_PI)) a_w2 = a_w1 - 38'(Q30_TWO_PI);
    else if (a_w1 <= -38'(Q30_PI)) a_w2 = a_w1 + 38'(Q30_TWO_PI);
    else a_w2 = a_w1;
    a_red = 36'(a_w2);
  end

  always_ff @(posedge clk) begin
    if (en) red_q <= a_red;
  end

  logic signed [33:0] zs [0:N];
  logic signed [33:0] xs [0:N];
  logic signed [33:0] ys [0:N];
  logic               fl [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= CORDIC_GAIN;
      ys[0] <= '0;
      if (red_q > Q30_HALF_PI) begin
        zs[0] <= 34'(Q30_PI - red_q);
        fl[0] <= 1'b1;
      end else if (red_q < -Q30_HALF_PI) begin
        zs[0] <= 34'(-Q30_PI - red_q);
        fl[0] <= 1'b1;
      end else begin
        zs[0] <= 34'(red_q);
        fl[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        fl[i+1] <= fl[i];
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - 34'(atan_q30(i));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + 34'(atan_q30(i));
        end
      end
    end
  end

  assign sin_q30 = ys[N];
  assign cos_q30 = fl[N] ? -xs[N] : xs[N];

endmodule

// ===== design/arm_forward_kinematics_top.sv =====
// ----------------------------------------------------------------------------
// arm_forward_kinematics_top
// Joint angles in, saturated ground-plane tool x/y out.
// ----------------------------------------------------------------------------
// Usage: write link lengths through cfg_we/cfg_index/cfg_data while idle.
// s_axis carries one word of four joint angles; m_axis returns one word of
// x_pos, y_pos and the saturated flag per input word, in order.
// Throughput: one word per cycle while the output is not stalled. The stages
// are the angle sum, the CORDIC stage chain, then the reach products, reach
// sum, rotate products and clip stages.
// The whole pipeline advances as one: when m_axis_tready is low and the
// output stage is full, every stage holds and s_axis_tready drops; nothing
// is lost or repeated. Reset clears all valid bits and the link registers.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_top
  import afk_pkg::*;
#(
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // base, shoulder, elbow, wrist angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // x_pos, y_pos, saturated, zero pad
);

  localparam int N   = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int LAT = N + 7;

  logic [15:0] upper_len, fore_len, wrist_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= '0;
      fore_len  <= '0;
      wrist_len <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UPPER: upper_len <= cfg_data;
        REG_FORE:  fore_len  <= cfg_data;
        REG_WRIST: wrist_len <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] vld;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], s_axis_tvalid};
  end

  // stage 1: angle sums
  logic signed [17:0] ang0, ang1, ang12, ang123;
  always_ff @(posedge clk) begin
    if (en) begin
      ang0   <= 18'($signed(s_axis_tdata[15:0]));
      ang1   <= 18'($signed(s_axis_tdata[31:16]));
      ang12  <= 18'($signed(s_axis_tdata[31:16])) + 18'($signed(s_axis_tdata[47:32]));
      ang123 <= 18'($signed(s_axis_tdata[31:16])) + 18'($signed(s_axis_tdata[47:32]))
              + 18'($signed(s_axis_tdata[63:48]));
    end
  end

  logic signed [33:0] s0, c0, s1, c1, s12, c12, s123, c123;

  afk_sincos #(.CORDIC_STAGES(CORDIC_STAGES))
    u_sc0 (.clk, .en, .angle(ang0), .sin_q30(s0), .cos_q30(c0));
  afk_sincos #(.CORDIC_STAGES(CORDIC_STAGES))
    u_sc1 (.clk, .en, .angle(ang1), .sin_q30(s1), .cos_q30(c1));
  afk_sincos #(.CORDIC_STAGES(CORDIC_STAGES))
    u_sc2 (.clk, .en, .angle(ang12), .sin_q30(s12), .cos_q30(c12));
  afk_sincos #(.CORDIC_STAGES(CORDIC_STAGES))
    u_sc3 (.clk, .en, .angle(ang123), .sin_q30(s123), .cos_q30(c123));

  // reach products
  logic signed [51:0] p1, p2, p3;
  logic signed [33:0] sd0, cd0;
  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= 52'(s1)   * 52'($signed({1'b0, upper_len}));
      p2  <= 52'(s12)  * 52'($signed({1'b0, fore_len}));
      p3  <= 52'(s123) * 52'($signed({1'b0, 17'(wrist_len) + TOOL_OFFSET}));
      sd0 <= s0;
      cd0 <= c0;
    end
  end

  // reach sum and round to Q30
  logic signed [53:0] rsum;
  logic signed [37:0] reach;
  logic signed [33:0] sd1, cd1;
  always_comb begin
    rsum = 54'(p1) + 54'(p2) + 54'(p3) + 54'sd32768;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      reach <= 38'(rsum >>> 16);
      sd1   <= sd0;
      cd1   <= cd0;
    end
  end

  // rotate by base angle
  logic signed [71:0] px, py;
  always_ff @(posedge clk) begin
    if (en) begin
      px <= 72'(reach) * 72'(cd1);
      py <= 72'(reach) * 72'(sd1);
    end
  end

  // round and clip
  logic signed [71:0] rx, ry;
  logic signed [25:0] vx_r, vy_r;
  logic               sx, sy;
  logic [15:0]        ox, oy;
  always_comb begin
    rx = (px + (72'sd1 <<< 45)) >>> 46;
    ry = (py + (72'sd1 <<< 45)) >>> 46;
    vx_r = 26'(rx);
    vy_r = 26'(ry);
    sx = (vx_r > 26'sd32767) || (vx_r < -26'sd32768);
    sy = (vy_r > 26'sd32767) || (vy_r < -26'sd32768);
    ox = (vx_r > 26'sd32767) ? 16'h7fff : (vx_r < -26'sd32768) ? 16'h8000 : vx_r[15:0];
    oy = (vy_r > 26'sd32767) ? 16'h7fff : (vy_r < -26'sd32768) ? 16'h8000 : vy_r[15:0];
  end

  logic [39:0] out_word;
  always_ff @(posedge clk) begin
    if (en) out_word <= {7'd0, sx || sy, oy, ox};
  end
  assign m_axis_tdata = out_word;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline stalled");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[39:33] == 7'd0)
    else $error("pad bits set");

endmodule

// ===== tb/arm_forward_kinematics_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_forward_kinematics_top_tb
// Checks joint-angle words against a bit-exact kinematics predictor.
// Link lengths are swept through zero, maximum and random settings. Each
// setting gets directed extreme angles, then random words. Both stream sides
// idle at random, but never in one phase. Another phase holds the output off
// long enough to stall the input. The sender drains before every link change.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_top_tb;
  import afk_pkg::*;

  localparam int LATENCY = CORDIC_STAGES_DEF + 7;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] wrist;
    logic signed [15:0] elbow;
    logic signed [15:0] shoulder;
    logic signed [15:0] base;
  } angles_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               sat;
  } tool_pt_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  arm_forward_kinematics_top dut (.*);

  always #5 clk = ~clk;

  angles_t  pending_words[$];
  tool_pt_t tool_pts[$];
  logic [15:0] len_upper, len_fore, len_wrist;
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int sat_seen = 0;
  int stall_cycles = 0;
  bit no_idle = 1'b0;
  bit timed_out = 1'b0;
  int idle_cycles = 0;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %0s: got %0d expected %0d (word %0d)", what, got, want, words_out);
  endtask

  function automatic void sincos_q30(input longint raw, output longint s,
                                     output longint c);
    longint a, x, y, dx, dy;
    bit flip;
    a = raw * (64'sd1 <<< (30 - ANGLE_FRAC_BITS_DEF));
    flip = 1'b0;
    while (a > Q30_PI) a -= Q30_TWO_PI;
    while (a <= -Q30_PI) a += Q30_TWO_PI;
    if (a > Q30_HALF_PI) begin
      a = Q30_PI - a;
      flip = 1'b1;
    end else if (a < -Q30_HALF_PI) begin
      a = -Q30_PI - a;
      flip = 1'b1;
    end
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= longint'(atan_q30(i));
      end else begin
        x += dx; y -= dy; a += longint'(atan_q30(i));
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic logic signed [15:0] clip_q14(input longint q60, inout logic sat);
    longint v;
    v = (q60 + (64'sd1 <<< 45)) >>> 46;
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic tool_pt_t predict_tool(input angles_t a);
    longint s1, c1, s12, c12, s123, c123, s0, c0, r46, r30;
    longint a1, a12, a123;
    tool_pt_t p;
    a1 = longint'(a.shoulder);
    a12 = a1 + longint'(a.elbow);
    a123 = a12 + longint'(a.wrist);
    sincos_q30(a1, s1, c1);
    sincos_q30(a12, s12, c12);
    sincos_q30(a123, s123, c123);
    sincos_q30(longint'(a.base), s0, c0);
    r46 = longint'(len_upper) * s1 + longint'(len_fore) * s12
        + (longint'(len_wrist) + longint'(TOOL_OFFSET)) * s123;
    r30 = (r46 + (64'sd1 <<< 15)) >>> 16;
    p.sat = 1'b0;
    p.x = clip_q14(r30 * c0, p.sat);
    p.y = clip_q14(r30 * s0, p.sat);
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        tool_pts.push_back(predict_tool(angles_t'(s_axis_tdata)));
        words_in++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 23)) begin
          s_axis_tdata  <= pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (tool_pts.size() == 0) begin
          report("unexpected word", longint'(m_axis_tdata), 0);
        end else begin
          tool_pt_t want;
          want = tool_pts.pop_front();
          if ($signed(m_axis_tdata[15:0]) != want.x)
            report("x_pos", longint'($signed(m_axis_tdata[15:0])), longint'(want.x));
          if ($signed(m_axis_tdata[31:16]) != want.y)
            report("y_pos", longint'($signed(m_axis_tdata[31:16])), longint'(want.y));
          if (m_axis_tdata[32] != want.sat)
            report("saturated", longint'(m_axis_tdata[32]), longint'(want.sat));
          if (m_axis_tdata[39:33] != '0)
            report("pad", longint'(m_axis_tdata[39:33]), 0);
          sat_seen += want.sat;
        end
        words_out++;
      end
      if (stall_cycles > 0) begin
        stall_cycles <= stall_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_idle || $urandom_range(99) >= 23;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst && !timed_out) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= WDOG_LIMIT) begin
        timed_out = 1'b1;
        $display("timeout: no handshake for %0d cycles", WDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || s_axis_tvalid || tool_pts.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_link(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_UPPER: len_upper = val;
      REG_FORE:  len_fore  = val;
      REG_WRIST: len_wrist = val;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(5))
      0: return 16'(16'h8000 + $urandom_range(3));
      1: return 16'(16'h7fff - $urandom_range(3));
      2: return 16'($urandom_range(25736) - 12868);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_directed();
    logic [15:0] edges[8] = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'd12868,
                              -16'sd12868, 16'd25736, -16'sd25736};
    angles_t a;
    for (int i = 0; i < 8; i++) begin
      a.base = edges[i]; a.shoulder = edges[(i + 4) % 8];
      a.elbow = edges[(i + 1) % 8]; a.wrist = edges[(i + 6) % 8];
      pending_words.push_back(a);
    end
    pending_words.push_back(angles_t'{16'h7fff, 16'h7fff, 16'h7fff, 16'h0000});
    pending_words.push_back(angles_t'{16'h8000, 16'h8000, 16'h8000, 16'h8000});
    pending_words.push_back(angles_t'{16'h0000, 16'h0000, 16'd12868, 16'd6434});
  endtask

  task automatic queue_random(input int n);
    angles_t a;
    repeat (n) begin
      a.base = rand_angle(); a.shoulder = rand_angle();
      a.elbow = rand_angle(); a.wrist = rand_angle();
      pending_words.push_back(a);
    end
  endtask

  initial begin
    logic [15:0] sets[6][3] = '{'{16'd0, 16'd0, 16'd0},
                                '{16'hffff, 16'hffff, 16'hffff},
                                '{16'd19661, 16'd16384, 16'd6554},
                                '{16'hffff, 16'd0, 16'h8000},
                                '{16'd0, 16'hffff, 16'd0},
                                '{16'd0, 16'd0, 16'd0}};
    len_upper = 0; len_fore = 0; len_wrist = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        sets[5][0] = 16'($urandom());
        sets[5][1] = 16'($urandom());
        sets[5][2] = 16'($urandom());
      end
      write_link(REG_UPPER, sets[ph][0]);
      write_link(REG_FORE, sets[ph][1]);
      write_link(REG_WRIST, sets[ph][2]);
      write_link(2'd3, 16'($urandom()));
      no_idle = (ph == 2);
      if (ph == 1) begin
        queue_directed();
        queue_random(20);
        @(posedge clk);
        stall_cycles = 200;
      end
      queue_directed();
      queue_random(240);
      drain();
    end
    no_idle = 1'b0;
    $display("covered %0d angle words over 6 link settings, %0d saturated results",
             words_in, sat_seen);
    if (errors == 0 && words_in == words_out) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
